// ===== sv/chf_pkg.sv =====
// Shared types and constants for the chunk hash find-or-insert block.
package chf_pkg;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_ALLOC,
        ST_RESP
    } chf_state_t;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    localparam logic [31:0] HASH_MUL_X = 32'd17;
    localparam logic [31:0] HASH_MUL_Y = 32'd13;
    localparam logic [31:0] HASH_MUL_Z = 32'd7;

endpackage

// ===== sv/chf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module chf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/chf_hash.sv =====
// Coordinate wrapping, key packing and bucket hash for one request.
module chf_hash #(
    parameter int COORD_BITS = 16,
    parameter int BUCKET_W   = 8
) (
    input  logic signed [15:0]           key_x,
    input  logic signed [15:0]           key_y,
    input  logic signed [15:0]           key_z,
    output logic [3*COORD_BITS-1:0]      key,
    output logic [BUCKET_W-1:0]          bucket
);

    import chf_pkg::*;

    logic signed [31:0]           ext_x;
    logic signed [31:0]           ext_y;
    logic signed [31:0]           ext_z;
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    logic signed [COORD_BITS-1:0] cz;
    logic [31:0]                  hx;
    logic [31:0]                  hy;
    logic [31:0]                  hz;
    logic [31:0]                  sum;

    // sign-extend, then wrap to the stored coordinate width
    assign ext_x = 32'(key_x);
    assign ext_y = 32'(key_y);
    assign ext_z = 32'(key_z);
    assign cx    = ext_x[COORD_BITS-1:0];
    assign cy    = ext_y[COORD_BITS-1:0];
    assign cz    = ext_z[COORD_BITS-1:0];

    assign key = {cz, cy, cx};

    assign hx  = 32'(cx);
    assign hy  = 32'(cy);
    assign hz  = 32'(cz);
    assign sum = hx * HASH_MUL_X + hy * HASH_MUL_Y + hz * HASH_MUL_Z;

    assign bucket = sum[BUCKET_W-1:0];

endmodule

// ===== sv/chunk_hash_find_or_insert.sv =====
// Top level: chained hash table over chunk coordinates with lookup and find-or-insert.
//
// Input channel (in_valid / in_stall) carries one request: op, key_x, key_y, key_z.
// op selects lookup only or find-or-insert. Output channel (out_valid / out_stall)
// returns one answer per request: hit, slot, created, pool_full.
// The table lives in one entry RAM (valid, link, key per entry): bucket heads at
// slots 0..BUCKETS-1, overflow entries after them, handed out from a bump pool.
// One request is in work at a time. After acceptance it reads its bucket head,
// then checks each visited chain entry while reading the next; an insert that
// links a new overflow entry passes through an allocation step before the answer
// register is loaded. The next request is accepted once the answer is loaded.
// Each visited entry costs a read of the entry RAM, so chain length sets the rate.
// After reset the block sweeps the bucket heads, one per cycle, and holds
// in_stall high meanwhile; overflow entries are initialized as they are
// allocated. The answer waits in an output register while out_stall is high,
// and the next request is accepted meanwhile; a later answer waits for it.
module chunk_hash_find_or_insert #(
    parameter int BUCKETS      = 256,
    parameter int POOL_ENTRIES = 256,
    parameter int COORD_BITS   = 16,
    localparam int IDX_W       = $clog2(BUCKETS + POOL_ENTRIES)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               op,
    input  logic signed [15:0] key_x,
    input  logic signed [15:0] key_y,
    input  logic signed [15:0] key_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               hit,
    output logic [IDX_W-1:0]   slot,
    output logic               created,
    output logic               pool_full
);

    import chf_pkg::*;

    localparam int TOTAL     = BUCKETS + POOL_ENTRIES;
    localparam int BUCKET_W  = $clog2(BUCKETS);
    localparam int KEY_W     = 3 * COORD_BITS;
    localparam int ENTRY_W   = 1 + IDX_W + KEY_W;
    localparam int PN_W      = $clog2(POOL_ENTRIES + 1);
    localparam int STEP_W    = $clog2(POOL_ENTRIES + 2);

    chf_state_t         state_reg, state_next;
    logic [BUCKET_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic               op_reg, op_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [IDX_W-1:0]   cur_reg, cur_next;
    logic [IDX_W-1:0]   fresh_reg, fresh_next;
    logic [STEP_W-1:0]  steps_reg, steps_next;
    logic [PN_W-1:0]    pool_next_reg, pool_next_next;
    logic               res_hit_reg, res_hit_next;
    logic [IDX_W-1:0]   res_slot_reg, res_slot_next;
    logic               res_created_reg, res_created_next;
    logic               res_full_reg, res_full_next;
    logic               out_valid_reg, out_valid_next;
    logic               hit_reg, hit_next;
    logic [IDX_W-1:0]   slot_reg, slot_next;
    logic               created_reg, created_next;
    logic               pool_full_reg, pool_full_next;

    logic [KEY_W-1:0]    hash_key;
    logic [BUCKET_W-1:0] hash_bucket;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    logic               rd_valid;
    logic [IDX_W-1:0]   rd_link;
    logic [KEY_W-1:0]   rd_key;
    logic               link_bad;
    logic               pool_empty;
    logic               out_load;

    chf_hash #(
        .COORD_BITS (COORD_BITS),
        .BUCKET_W   (BUCKET_W)
    ) u_hash (
        .key_x  (key_x),
        .key_y  (key_y),
        .key_z  (key_z),
        .key    (hash_key),
        .bucket (hash_bucket)
    );

    chf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TOTAL)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_key   = ram_rdata[KEY_W-1:0];
    assign rd_link  = ram_rdata[KEY_W +: IDX_W];
    assign rd_valid = ram_rdata[ENTRY_W-1];

    assign link_bad   = ({1'b0, rd_link} >= (IDX_W + 1)'(TOTAL));
    assign pool_empty = (pool_next_reg == PN_W'(POOL_ENTRIES));
    assign out_load   = (state_reg == ST_RESP) && (!out_valid_reg || !out_stall);

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign slot      = slot_reg;
    assign created   = created_reg;
    assign pool_full = pool_full_reg;

    always_comb
    begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        op_next          = op_reg;
        key_next         = key_reg;
        cur_next         = cur_reg;
        fresh_next       = fresh_reg;
        steps_next       = steps_reg;
        pool_next_next   = pool_next_reg;
        res_hit_next     = res_hit_reg;
        res_slot_next    = res_slot_reg;
        res_created_next = res_created_reg;
        res_full_next    = res_full_reg;
        ram_we           = 1'b0;
        ram_waddr        = cur_reg;
        ram_wdata        = '0;
        ram_re           = 1'b0;
        ram_raddr        = cur_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = IDX_W'(clr_cnt_reg);
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == BUCKET_W'(BUCKETS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = op;
                    key_next   = hash_key;
                    cur_next   = IDX_W'(hash_bucket);
                    steps_next = '0;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                ram_re     = 1'b1;
                ram_raddr  = cur_reg;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                priority if (rd_valid && rd_key == key_reg)
                begin
                    res_hit_next     = 1'b1;
                    res_slot_next    = cur_reg;
                    res_created_next = 1'b0;
                    res_full_next    = 1'b0;
                    state_next       = ST_RESP;
                end
                else if (op_reg == OP_INSERT && rd_valid && rd_link == '0)
                begin
                    if (pool_empty)
                    begin
                        res_hit_next     = 1'b0;
                        res_slot_next    = '0;
                        res_created_next = 1'b0;
                        res_full_next    = 1'b1;
                        state_next       = ST_RESP;
                    end
                    else
                    begin
                        // link the tail to a fresh overflow entry, claimed next cycle
                        fresh_next     = IDX_W'(BUCKETS) + IDX_W'(pool_next_reg);
                        pool_next_next = pool_next_reg + 1'b1;
                        ram_we         = 1'b1;
                        ram_waddr      = cur_reg;
                        ram_wdata      = {1'b1, IDX_W'(BUCKETS) + IDX_W'(pool_next_reg),
                                          rd_key};
                        state_next     = ST_ALLOC;
                    end
                end
                else if (op_reg == OP_INSERT && !rd_valid)
                begin
                    ram_we           = 1'b1;
                    ram_waddr        = cur_reg;
                    ram_wdata        = {1'b1, rd_link, key_reg};
                    res_hit_next     = 1'b1;
                    res_slot_next    = cur_reg;
                    res_created_next = 1'b1;
                    res_full_next    = 1'b0;
                    state_next       = ST_RESP;
                end
                else if (rd_link == '0 || link_bad || steps_reg == STEP_W'(POOL_ENTRIES + 1))
                begin
                    res_hit_next     = 1'b0;
                    res_slot_next    = '0;
                    res_created_next = 1'b0;
                    res_full_next    = 1'b0;
                    state_next       = ST_RESP;
                end
                else
                begin
                    // advance along the chain
                    cur_next   = rd_link;
                    steps_next = steps_reg + 1'b1;
                    ram_re     = 1'b1;
                    ram_raddr  = rd_link;
                end
            end
            ST_ALLOC:
            begin
                ram_we           = 1'b1;
                ram_waddr        = fresh_reg;
                ram_wdata        = {1'b1, {IDX_W{1'b0}}, key_reg};
                res_hit_next     = 1'b1;
                res_slot_next    = fresh_reg;
                res_created_next = 1'b1;
                res_full_next    = 1'b0;
                state_next       = ST_RESP;
            end
            ST_RESP:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        hit_next       = hit_reg;
        slot_next      = slot_reg;
        created_next   = created_reg;
        pool_full_next = pool_full_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            hit_next       = res_hit_reg;
            slot_next      = res_slot_reg;
            created_next   = res_created_reg;
            pool_full_next = res_full_reg;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            steps_reg     <= '0;
            pool_next_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            steps_reg     <= steps_next;
            pool_next_reg <= pool_next_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        key_reg         <= key_next;
        cur_reg         <= cur_next;
        fresh_reg       <= fresh_next;
        res_hit_reg     <= res_hit_next;
        res_slot_reg    <= res_slot_next;
        res_created_reg <= res_created_next;
        res_full_reg    <= res_full_next;
        hit_reg         <= hit_next;
        slot_reg        <= slot_next;
        created_reg     <= created_next;
        pool_full_reg   <= pool_full_next;
    end

endmodule

// ===== sv/chf_checker.sv =====
// Port-level checks for the chunk hash find-or-insert block, bound to its top level.
module chf_checker #(
    parameter int SLOT_W = 9
) (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic              hit,
    input logic [SLOT_W-1:0] slot,
    input logic              created,
    input logic              pool_full
);

    // one request in work at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request accepted while previous one still in work");

    a_created_is_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && created |-> hit && !pool_full)
        else $error("created answer without hit");

    a_full_answer: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pool_full |-> !hit && !created && slot == '0)
        else $error("pool exhausted answer carries an entry");

    a_miss_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> slot == '0 && !created)
        else $error("miss answer carries a slot");

    a_hold_answer: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(slot) && $stable(hit))
        else $error("stalled answer changed");

endmodule

bind chunk_hash_find_or_insert chf_checker #(
    .SLOT_W (IDX_W)
) u_chf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .hit       (hit),
    .slot      (slot),
    .created   (created),
    .pool_full (pool_full)
);
